// File: rtl/dtes_pkg.sv
package dtes_pkg;

    // field widths
    localparam int FREQ_W   = 15;
    localparam int LEN_W    = 16;
    localparam int DAC_W    = 16;
    localparam int STEP_W   = 15;
    localparam int PHASE_W  = 32;
    localparam int AMP_W    = 32;
    localparam int SINE_W   = 27;
    localparam int PROD_W   = AMP_W + SINE_W;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // sine table geometry
    localparam int SINE_ENTRIES = 256;
    localparam int SINE_AW      = $clog2(SINE_ENTRIES);

    // request codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // output word constants
    localparam logic [DAC_W-1:0] DAC_CHAN_B = 16'hB000;
    localparam logic [DAC_W-1:0] DAC_MID    = 16'd2048;
    localparam logic [FREQ_W-1:0] FREQ_MAX  = 15'd24999;

    // level = (amp * sine) >>> 30, low 16 bits only
    localparam int LEVEL_LSB = 30;

    // phase increment = floor(f * 2^28 / 3125)
    //   = f * WHOLE + floor(f * REM / 3125), the second term by reciprocal
    localparam logic [63:0] PINC_DIV   = 64'd3125;
    localparam logic [63:0] PINC_WHOLE = (64'd1 << 28) / PINC_DIV;
    localparam logic [63:0] PINC_REM   = (64'd1 << 28) - PINC_WHOLE * PINC_DIV;
    localparam int          PINC_SHIFT = 37;
    localparam logic [63:0] PINC_RECIP = ((64'd1 << PINC_SHIFT) + PINC_DIV - 64'd1) / PINC_DIV;
    localparam int PINC_WHOLE_W = 17;
    localparam int PINC_REM_W   = 11;
    localparam int PINC_PART_W  = 25;
    localparam int PINC_RECIP_W = 26;
    localparam int PINC_QP_W    = PINC_PART_W + PINC_RECIP_W;
    localparam int PINC_QUO_W   = PINC_QP_W - PINC_SHIFT;

    // register map
    typedef enum logic [1:0] {
        REG_ATTACK_STEP = 2'd0,
        REG_DECAY_STEP  = 2'd1,
        REG_ATTACK_LEN  = 2'd2,
        REG_DECAY_LEN   = 2'd3
    } t_reg_idx;

    localparam logic [STEP_W-1:0] ATTACK_STEP_RST = 15'd131;
    localparam logic [STEP_W-1:0] DECAY_STEP_RST  = 15'd131;
    localparam logic [LEN_W-1:0]  ATTACK_LEN_RST  = 16'd250;
    localparam logic [LEN_W-1:0]  DECAY_LEN_RST   = 16'd250;

    typedef struct packed {
        logic [STEP_W-1:0] attack_step;
        logic [STEP_W-1:0] decay_step;
        logic [LEN_W-1:0]  attack_len;
        logic [LEN_W-1:0]  decay_len;
    } t_cfg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INC,
        ST_ROM,
        ST_OUT
    } t_state;

    typedef logic signed [SINE_W-1:0] t_sine_tab [SINE_ENTRIES];

    // pi in Q60
    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] PEAK_SCALE = 64'd67076096;
    localparam int          SIN_TERMS  = 13;

    // floor(a*b / 2^60), full product
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // floor(a / b) by shift and subtract, for table construction only
    function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // trunc(32768*2047*sin(k*6.283/256)) by a fixed-point Taylor series
    function automatic logic signed [SINE_W-1:0] sine_entry(input int k);
        logic [63:0] num;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] dv;
        logic        neg;
        num = 64'(k) * 64'd6283;
        x   = ((num / 64'd125) << 49) + (((num % 64'd125) << 49) / 64'd125);
        neg = 1'b0;
        if (x >= PI_Q60) begin
            x   = x - PI_Q60;
            neg = 1'b1;
        end
        if (x > (PI_Q60 >> 1)) begin
            x = PI_Q60 - x;
        end
        x2 = mul_q60(x, x);
        t  = x;
        s  = x;
        for (int n = 1; n <= SIN_TERMS; n++) begin
            dv = 64'(2 * n) * 64'(2 * n + 1);
            t  = div_u64(mul_q60(t, x2), dv);
            if ((n % 2) == 1) begin
                s = s - t;
            end else begin
                s = s + t;
            end
        end
        s = mul_q60(s, PEAK_SCALE);
        return neg ? -$signed(s[SINE_W-1:0]) : $signed(s[SINE_W-1:0]);
    endfunction

    function automatic t_sine_tab sine_table_build();
        t_sine_tab tab;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            tab[k] = sine_entry(k);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TABLE = sine_table_build();

endpackage

// File: rtl/dtes_if.sv
// request channel: tick or start
interface dtes_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [dtes_pkg::FREQ_W-1:0]  freq_hz;
    logic [dtes_pkg::LEN_W-1:0]   sound_len;

    modport source (output valid, output req_type, output freq_hz, output sound_len,
                    input ready);
    modport sink   (input valid, input req_type, input freq_hz, input sound_len,
                    output ready);
endinterface

// result channel: one DAC word per tick
interface dtes_res_if;
    logic                        valid;
    logic                        ready;
    logic [dtes_pkg::DAC_W-1:0]  dac_word;
    logic                        last_sample;

    modport source (output valid, output dac_word, output last_sample, input ready);
    modport sink   (input valid, input dac_word, input last_sample, output ready);
endinterface

// File: rtl/dtes_apb_regs.sv
module dtes_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtes_pkg::APB_AW-1:0]   paddr,
    input  logic [dtes_pkg::APB_DW-1:0]   pwdata,
    output logic [dtes_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output dtes_pkg::t_cfg                o_cfg
);

    dtes_pkg::t_cfg   r_cfg;
    dtes_pkg::t_reg_idx idx;
    logic             wr_en;

    assign idx    = dtes_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step <= dtes_pkg::ATTACK_STEP_RST;
            r_cfg.decay_step  <= dtes_pkg::DECAY_STEP_RST;
            r_cfg.attack_len  <= dtes_pkg::ATTACK_LEN_RST;
            r_cfg.decay_len   <= dtes_pkg::DECAY_LEN_RST;
        end else if (wr_en) begin
            case (idx)
                dtes_pkg::REG_ATTACK_STEP: r_cfg.attack_step <= pwdata[dtes_pkg::STEP_W-1:0];
                dtes_pkg::REG_DECAY_STEP:  r_cfg.decay_step  <= pwdata[dtes_pkg::STEP_W-1:0];
                dtes_pkg::REG_ATTACK_LEN:  r_cfg.attack_len  <= pwdata[dtes_pkg::LEN_W-1:0];
                dtes_pkg::REG_DECAY_LEN:   r_cfg.decay_len   <= pwdata[dtes_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            dtes_pkg::REG_ATTACK_STEP: prdata = 32'(r_cfg.attack_step);
            dtes_pkg::REG_DECAY_STEP:  prdata = 32'(r_cfg.decay_step);
            dtes_pkg::REG_ATTACK_LEN:  prdata = 32'(r_cfg.attack_len);
            dtes_pkg::REG_DECAY_LEN:   prdata = 32'(r_cfg.decay_len);
            default:                   prdata = '0;
        endcase
    end

endmodule

// File: rtl/dtes_phase_inc.sv
// floor(f * 2^28 / 3125) in three stages: split multiply, reciprocal, sum
module dtes_phase_inc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dtes_pkg::FREQ_W-1:0]    i_freq,
    output logic                           o_done,
    output logic [dtes_pkg::PHASE_W-1:0]   o_inc
);

    localparam int PartW = dtes_pkg::PINC_PART_W;
    localparam int QpW   = dtes_pkg::PINC_QP_W;

    logic [2:0]                       r_vld;
    logic [dtes_pkg::PHASE_W-1:0]     r_whole;
    logic [dtes_pkg::PHASE_W-1:0]     r_whole2;
    logic [PartW-1:0]                 r_part;
    logic [QpW-1:0]                   r_qp;
    logic [dtes_pkg::PHASE_W-1:0]     r_inc;
    logic [dtes_pkg::PHASE_W-1:0]     whole;
    logic [PartW-1:0]                 part;
    logic [QpW-1:0]                   qp;
    logic [dtes_pkg::PINC_QUO_W-1:0]  quo;

    assign whole = 32'(i_freq) * 32'(dtes_pkg::PINC_WHOLE[dtes_pkg::PINC_WHOLE_W-1:0]);
    assign part  = PartW'(i_freq) * PartW'(dtes_pkg::PINC_REM[dtes_pkg::PINC_REM_W-1:0]);
    assign qp    = QpW'(r_part) * QpW'(dtes_pkg::PINC_RECIP[dtes_pkg::PINC_RECIP_W-1:0]);
    assign quo   = r_qp[QpW-1:dtes_pkg::PINC_SHIFT];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_whole  <= whole;
        r_part   <= part;
        r_whole2 <= r_whole;
        r_qp     <= qp;
        r_inc    <= r_whole2 + dtes_pkg::PHASE_W'(quo);
    end

    assign o_done = r_vld[2];
    assign o_inc  = r_inc;

endmodule

// File: rtl/dtes_sine_rom.sv
// sine table, registered read
module dtes_sine_rom (
    input  logic                                i_clk,
    input  logic [dtes_pkg::SINE_AW-1:0]        i_addr,
    output logic signed [dtes_pkg::SINE_W-1:0]  o_data
);

    logic signed [dtes_pkg::SINE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= dtes_pkg::SINE_TABLE[i_addr];
    end

    assign o_data = r_data;

endmodule

// File: rtl/dds_tone_envelope_synth.sv
// Tone synthesizer with a linear attack/decay envelope. A start word latches the sound
// length and clears phase, amplitude and sample count; a zero length leaves the block
// idle. Each tick word while a sound plays yields one DAC word 0xB000|(level+2048) in
// steps: the phase-increment unit (split multiply and reciprocal divide by 3125), the
// sine ROM read, registered together with the new phase, the scale multiply and
// envelope update, and the load of the output register. The input is held off until
// that load, so no tick is taken while the last one is in progress, and ticks wait
// longer while the output register stays full. Ticks while idle are taken and dropped.
// The block takes a new word as soon as the previous one is done, even while its result
// still waits in the output register. No clearing pass at reset.
module dds_tone_envelope_synth (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dtes_req_if.sink                      i_req,
    dtes_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtes_pkg::APB_AW-1:0]   paddr,
    input  logic [dtes_pkg::APB_DW-1:0]   pwdata,
    output logic [dtes_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int PhW = dtes_pkg::PHASE_W;
    localparam int AmW = dtes_pkg::AMP_W;
    localparam int LnW = dtes_pkg::LEN_W;
    localparam int DcW = dtes_pkg::DAC_W;

    dtes_pkg::t_cfg   cfg;
    dtes_pkg::t_state r_state, n_state;

    logic [PhW-1:0]  r_phase, n_phase;
    logic [AmW-1:0]  r_amp, n_amp;
    logic [LnW-1:0]  r_count, n_count;
    logic [LnW-1:0]  r_len, n_len;
    logic            r_playing, n_playing;
    logic [DcW-1:0]  r_level, n_level;
    logic            r_last, n_last;
    logic            r_out_valid, n_out_valid;
    logic [DcW-1:0]  r_out_word, n_out_word;
    logic            r_out_last, n_out_last;

    logic                                 accept;
    logic                                 inc_start;
    logic                                 inc_done;
    logic [PhW-1:0]                       inc;
    logic [dtes_pkg::FREQ_W-1:0]          freq_sat;
    logic [PhW-1:0]                       phase_sum;
    logic signed [dtes_pkg::SINE_W-1:0]   sine;
    logic signed [dtes_pkg::PROD_W-1:0]   prod;
    logic [LnW-1:0]                       cnt_inc;
    logic                                 out_free;

    dtes_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dtes_phase_inc u_pinc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (inc_start),
        .i_freq  (freq_sat),
        .o_done  (inc_done),
        .o_inc   (inc)
    );

    dtes_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (phase_sum[PhW-1 -: dtes_pkg::SINE_AW]),
        .o_data (sine)
    );

    // input side
    assign i_req.ready = (r_state == dtes_pkg::ST_IDLE);
    assign accept      = i_req.valid & i_req.ready;
    assign freq_sat    = (i_req.freq_hz > dtes_pkg::FREQ_MAX) ? dtes_pkg::FREQ_MAX
                                                               : i_req.freq_hz;
    assign inc_start   = accept & (i_req.req_type == dtes_pkg::REQ_TICK) & r_playing;

    // datapath terms
    assign phase_sum = r_phase + inc;
    assign prod      = $signed(r_amp) * sine;
    assign cnt_inc   = r_count + 16'd1;
    assign out_free  = ~r_out_valid | o_res.ready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_amp       = r_amp;
        n_count     = r_count;
        n_len       = r_len;
        n_playing   = r_playing;
        n_level     = r_level;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            dtes_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == dtes_pkg::REQ_START) begin
                        n_len     = i_req.sound_len;
                        n_phase   = '0;
                        n_amp     = '0;
                        n_count   = '0;
                        n_playing = (i_req.sound_len != '0);
                    end else if (r_playing) begin
                        n_state = dtes_pkg::ST_INC;
                    end
                end
            end
            dtes_pkg::ST_INC: begin
                // ROM address comes from the new phase
                if (inc_done) begin
                    n_phase = phase_sum;
                    n_state = dtes_pkg::ST_ROM;
                end
            end
            dtes_pkg::ST_ROM: begin
                n_level = prod[dtes_pkg::LEVEL_LSB +: DcW];
                // envelope on the old count
                if (r_count < cfg.attack_len) begin
                    n_amp = r_amp + AmW'(cfg.attack_step);
                end else if (r_len >= cfg.decay_len && r_count > (r_len - cfg.decay_len)) begin
                    n_amp = r_amp - AmW'(cfg.decay_step);
                end
                n_count = cnt_inc;
                n_last  = (cnt_inc == r_len);
                if (cnt_inc == r_len) begin
                    n_playing = 1'b0;
                    n_phase   = '0;
                    n_amp     = '0;
                    n_count   = '0;
                end
                n_state = dtes_pkg::ST_OUT;
            end
            dtes_pkg::ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = dtes_pkg::DAC_CHAN_B | (r_level + dtes_pkg::DAC_MID);
                    n_out_last  = r_last;
                    n_state     = dtes_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dtes_pkg::ST_IDLE;
            end
        endcase
    end

    // control and voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtes_pkg::ST_IDLE;
            r_phase     <= '0;
            r_amp       <= '0;
            r_count     <= '0;
            r_len       <= '0;
            r_playing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_amp       <= n_amp;
            r_count     <= n_count;
            r_len       <= n_len;
            r_playing   <= n_playing;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_level    <= n_level;
        r_last     <= n_last;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.dac_word    = r_out_word;
    assign o_res.last_sample = r_out_last;

    // a start clears the voice state
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.req_type == dtes_pkg::REQ_START
        |=> r_phase == '0 && r_amp == '0 && r_count == '0)
        else $error("start did not clear voice state");

    // work on a tick only while a sound plays
    a_busy_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dtes_pkg::ST_INC || r_state == dtes_pkg::ST_ROM |-> r_playing)
        else $error("tick in progress while idle");

    // a free output slot in the output state is loaded at once
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dtes_pkg::ST_OUT && out_free
        |=> r_out_valid && r_state == dtes_pkg::ST_IDLE)
        else $error("result not loaded");

    // a finished sound leaves the count cleared
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dtes_pkg::ST_ROM && cnt_inc == r_len
        |=> !r_playing && r_count == '0 && r_last)
        else $error("sound end not handled");

endmodule
